>>> hdl/assert_macros.svh
// Assertion helpers used by the bpa_props checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

>>> hdl/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

    localparam int BPA_PAGE_BITS = 16;

    localparam logic [1:0] FN_ALLOC = 2'd0;
    localparam logic [1:0] FN_FREE  = 2'd1;
    localparam logic [1:0] FN_INIT  = 2'd2;
    localparam logic [1:0] FN_NOP   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_EXCEED  = 3'd2;
    localparam logic [2:0] ST_NOBLOCK = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    localparam logic [1:0] CFG_REGION_START = 2'd0;
    localparam logic [1:0] CFG_REGION_PAGES = 2'd1;

    localparam logic [4:0] ORDER_LIMIT = 5'd16;

    typedef struct packed {
        logic       free;
        logic [4:0] order;
    } t_entry;

    // floor(log2(v)), zero for v below two
    function automatic logic [4:0] flog2(input logic [16:0] v);
        logic [4:0] r;
        r = '0;
        for (int b = 0; b < 17; b++) begin
            if (v[b]) r = 5'(b);
        end
        return r;
    endfunction

    // ceil(log2(n)), zero for n below two
    function automatic logic [4:0] clog2n(input logic [16:0] n);
        logic [4:0] r;
        r = '0;
        if (n > 17'd1) r = flog2(n - 17'd1) + 5'd1;
        return r;
    endfunction

    // trailing zero count, 17 for zero
    function automatic logic [4:0] ctz(input logic [16:0] v);
        logic [4:0] r;
        r = 5'd17;
        for (int b = 16; b >= 0; b--) begin
            if (v[b]) r = 5'(b);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/bpa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bpa_ram #(
    parameter int W = 6,
    parameter int D = 65536
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hdl/buddy_page_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Func 3 and early errors go straight to S_DONE, which loads the output register once
// it is free; alloc scans one entry per cycle for each order searched, then splits the block
// down to the requested order; free scans its block, reads its ancestors and merges buddies;
// init sweeps 2^AW entries, then writes one block per cycle.
// One request at a time; the next is taken the cycle after its result is loaded.
// Reset: synchronous, active low; all 2^AW entries are cleared before the first request.
module buddy_page_allocator #(
    parameter int PAGE_BITS = bpa_pkg::BPA_PAGE_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [16:0] i_page_count,
    input  wire logic [15:0] i_page_index,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [15:0]      o_block_page,
    output logic [16:0]      o_free_count,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data
);
    localparam int AW = (PAGE_BITS < 16) ? PAGE_BITS : 16;
    localparam int DEPTH = 1 << AW;
    localparam logic [17:0] SPACE_W = 18'(DEPTH);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLR     = 4'd1;
    localparam logic [3:0] S_A_SCAN  = 4'd2;
    localparam logic [3:0] S_A_SPLIT = 4'd3;
    localparam logic [3:0] S_F_SCAN  = 4'd4;
    localparam logic [3:0] S_F_UP    = 4'd5;
    localparam logic [3:0] S_F_MRD   = 4'd6;
    localparam logic [3:0] S_F_MCK   = 4'd7;
    localparam logic [3:0] S_F_FIN   = 4'd8;
    localparam logic [3:0] S_I_CARVE = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]  r_state, n_state;
    logic [15:0] r_region_start, n_region_start;
    logic [16:0] r_region_pages, n_region_pages;
    logic [16:0] r_free, n_free;
    logic [4:0]  r_top, n_top;
    logic        r_init, n_init;
    logic [17:0] r_addr, n_addr;
    logic        r_pend, n_pend;
    logic [16:0] r_paddr, n_paddr;
    logic [17:0] r_end, n_end;
    logic [16:0] r_base, n_base;
    logic [17:0] r_size, n_size;
    logic [4:0]  r_ord, n_ord;
    logic [4:0]  r_i, n_i;
    logic [4:0]  r_j, n_j;
    logic [16:0] r_rem, n_rem;
    logic [2:0]  r_status, n_status;
    logic [15:0] r_page, n_page;
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_out_status, n_out_status;
    logic [15:0] r_out_page, n_out_page;
    logic [16:0] r_out_free, n_out_free;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    bpa_pkg::t_entry     ram_wdata;
    bpa_pkg::t_entry     ram_rdata;
    logic [5:0]          ram_rbits;

    bpa_ram #(
        .W(6),
        .D(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rbits)
    );
    assign ram_rdata = bpa_pkg::t_entry'(ram_rbits);

    // region bounds, clipped to the page space
    logic [17:0] reg_end, reg_hi;
    logic [17:0] reg_lo;
    logic [16:0] reg_count;
    assign reg_lo    = {2'b00, r_region_start};
    assign reg_end   = reg_lo + {1'b0, r_region_pages};
    assign reg_hi    = (reg_end > SPACE_W) ? SPACE_W : reg_end;
    assign reg_count = (reg_hi > reg_lo) ? 17'(reg_hi - reg_lo) : 17'd0;

    logic [4:0]  req_ord;
    logic [17:0] req_size;
    logic [17:0] req_base;
    logic        free_bad;
    assign req_ord  = bpa_pkg::clog2n(i_page_count);
    assign req_size = (req_ord > bpa_pkg::ORDER_LIMIT) ? 18'd0 : (18'd1 << req_ord);
    assign req_base = {2'b00, i_page_index};
    assign free_bad = (req_ord > bpa_pkg::ORDER_LIMIT) || (req_base < reg_lo) ||
                      (req_base >= reg_hi) || (req_size > (reg_hi - req_base)) ||
                      ((req_base & (req_size - 18'd1)) != 18'd0) ||
                      (({1'b0, r_free} + req_size) > 18'd65536);

    logic [17:0] a_step, a_half;
    logic [16:0] up_mask, up_addr, up_diff;
    logic [17:0] buddy;
    logic [4:0]  carve_o;
    logic [17:0] carve_blk;
    logic [4:0]  fl_rem, tz_p;
    logic [17:0] r_p18;

    assign a_step    = 18'd1 << r_i;
    assign a_half    = 18'd1 << (r_j - 5'd1);
    assign up_mask   = (17'd1 << r_j) - 17'd1;
    assign up_addr   = r_base & ~up_mask;
    assign up_diff   = r_base - r_paddr;
    assign buddy     = {1'b0, r_base} ^ r_size;
    assign fl_rem    = bpa_pkg::flog2(r_rem);
    assign tz_p      = bpa_pkg::ctz(r_paddr);
    assign carve_o   = (fl_rem < tz_p) ? fl_rem : tz_p;
    assign carve_blk = 18'd1 << carve_o;
    assign r_p18     = {1'b0, r_paddr};

    always_comb begin
        n_state        = r_state;
        n_region_start = r_region_start;
        n_region_pages = r_region_pages;
        n_free         = r_free;
        n_top          = r_top;
        n_init         = r_init;
        n_addr         = r_addr;
        n_pend         = r_pend;
        n_paddr        = r_paddr;
        n_end          = r_end;
        n_base         = r_base;
        n_size         = r_size;
        n_ord          = r_ord;
        n_i            = r_i;
        n_j            = r_j;
        n_rem          = r_rem;
        n_status       = r_status;
        n_page         = r_page;
        n_out_valid    = r_out_valid;
        n_out_status   = r_out_status;
        n_out_page     = r_out_page;
        n_out_free     = r_out_free;
        ram_we         = 1'b0;
        ram_waddr      = r_addr[AW-1:0];
        ram_wdata      = '0;
        ram_raddr      = r_addr[AW-1:0];

        if (i_cfg_valid) begin
            if (i_cfg_index == bpa_pkg::CFG_REGION_START) n_region_start = i_cfg_data[15:0];
            else if (i_cfg_index == bpa_pkg::CFG_REGION_PAGES) n_region_pages = i_cfg_data;
        end

        if (r_out_valid && i_ready) n_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_page   = '0;
                    n_status = bpa_pkg::ST_OK;
                    n_pend   = 1'b0;
                    n_state  = S_DONE;
                    unique case (i_func)
                        bpa_pkg::FN_ALLOC: begin
                            if (i_page_count == 17'd0) n_status = bpa_pkg::ST_ZERO;
                            else if (i_page_count > r_free) n_status = bpa_pkg::ST_EXCEED;
                            else if (req_ord > r_top) n_status = bpa_pkg::ST_NOBLOCK;
                            else begin
                                n_ord   = req_ord;
                                n_i     = req_ord;
                                n_addr  = '0;
                                n_state = S_A_SCAN;
                            end
                        end
                        bpa_pkg::FN_FREE: begin
                            if (i_page_count == 17'd0) n_status = bpa_pkg::ST_ZERO;
                            else if (free_bad) n_status = bpa_pkg::ST_INVALID;
                            else begin
                                n_ord   = req_ord;
                                n_size  = req_size;
                                n_base  = {1'b0, i_page_index};
                                n_addr  = req_base;
                                n_end   = req_base + req_size;
                                n_state = S_F_SCAN;
                            end
                        end
                        bpa_pkg::FN_INIT: begin
                            n_top   = bpa_pkg::flog2(reg_count);
                            n_free  = '0;
                            n_paddr = reg_lo[16:0];
                            n_rem   = reg_count;
                            n_addr  = '0;
                            n_init  = 1'b1;
                            n_state = S_CLR;
                        end
                        bpa_pkg::FN_NOP: ;
                    endcase
                end
            end
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr[AW-1:0];
                n_addr    = r_addr + 18'd1;
                if (r_addr == SPACE_W - 18'd1) begin
                    n_state = r_init ? S_I_CARVE : S_IDLE;
                    n_init  = 1'b0;
                end
            end
            S_A_SCAN: begin
                if (r_pend && ram_rdata.free && ram_rdata.order == r_i) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_paddr[AW-1:0];
                    n_free    = r_free - a_step[16:0];
                    n_base    = r_paddr;
                    n_j       = r_i;
                    n_pend    = 1'b0;
                    n_state   = S_A_SPLIT;
                end else if (r_addr < SPACE_W) begin
                    n_pend  = 1'b1;
                    n_paddr = r_addr[16:0];
                    n_addr  = r_addr + a_step;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_i == r_top) begin
                            n_status = bpa_pkg::ST_NOBLOCK;
                            n_state  = S_DONE;
                        end else begin
                            n_i    = r_i + 5'd1;
                            n_addr = '0;
                        end
                    end
                end
            end
            S_A_SPLIT: begin
                if (r_j > r_ord) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'({1'b0, r_base} + a_half);
                    ram_wdata = '{free: 1'b1, order: r_j - 5'd1};
                    n_free    = 17'({1'b0, r_free} + a_half);
                    n_j       = r_j - 5'd1;
                end else begin
                    n_status = bpa_pkg::ST_OK;
                    n_page   = r_base[15:0];
                    n_state  = S_DONE;
                end
            end
            S_F_SCAN: begin
                if (r_pend && ram_rdata.free) begin
                    n_status = bpa_pkg::ST_INVALID;
                    n_pend   = 1'b0;
                    n_state  = S_DONE;
                end else if (r_addr < r_end) begin
                    n_pend  = 1'b1;
                    n_paddr = r_addr[16:0];
                    n_addr  = r_addr + 18'd1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_j     = 5'd1;
                        n_state = S_F_UP;
                    end
                end
            end
            S_F_UP: begin
                ram_raddr = up_addr[AW-1:0];
                if (r_pend && ram_rdata.free &&
                    (ram_rdata.order > bpa_pkg::ORDER_LIMIT ||
                     (up_diff >> ram_rdata.order) == 17'd0)) begin
                    n_status = bpa_pkg::ST_INVALID;
                    n_pend   = 1'b0;
                    n_state  = S_DONE;
                end else if (r_j <= bpa_pkg::ORDER_LIMIT) begin
                    n_pend  = (up_addr < r_base);
                    n_paddr = up_addr;
                    n_j     = r_j + 5'd1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_free  = 17'({1'b0, r_free} + r_size);
                        n_state = S_F_MRD;
                    end
                end
            end
            S_F_MRD: begin
                ram_raddr = buddy[AW-1:0];
                n_paddr   = buddy[16:0];
                if (r_ord < r_top && buddy < SPACE_W) n_state = S_F_MCK;
                else n_state = S_F_FIN;
            end
            S_F_MCK: begin
                if (ram_rdata.free && ram_rdata.order == r_ord) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_paddr[AW-1:0];
                    if (r_paddr < r_base) n_base = r_paddr;
                    n_ord   = r_ord + 5'd1;
                    n_size  = r_size << 1;
                    n_state = S_F_MRD;
                end else begin
                    n_state = S_F_FIN;
                end
            end
            S_F_FIN: begin
                ram_we    = 1'b1;
                ram_waddr = r_base[AW-1:0];
                ram_wdata = '{free: 1'b1, order: r_ord};
                n_status  = bpa_pkg::ST_OK;
                n_state   = S_DONE;
            end
            S_I_CARVE: begin
                if (r_rem != 17'd0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_paddr[AW-1:0];
                    ram_wdata = '{free: 1'b1, order: carve_o};
                    n_free    = 17'({1'b0, r_free} + carve_blk);
                    n_paddr   = 17'(r_p18 + carve_blk);
                    n_rem     = 17'({1'b0, r_rem} - carve_blk);
                end else begin
                    n_status = bpa_pkg::ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_page   = (r_status == bpa_pkg::ST_OK) ? r_page : 16'd0;
                    n_out_free   = r_free;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLR;
            r_region_start <= '0;
            r_region_pages <= '0;
            r_free         <= '0;
            r_top          <= '0;
            r_init         <= 1'b0;
            r_addr         <= '0;
            r_pend         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_region_start <= n_region_start;
            r_region_pages <= n_region_pages;
            r_free         <= n_free;
            r_top          <= n_top;
            r_init         <= n_init;
            r_addr         <= n_addr;
            r_pend         <= n_pend;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr      <= n_paddr;
        r_end        <= n_end;
        r_base       <= n_base;
        r_size       <= n_size;
        r_ord        <= n_ord;
        r_i          <= n_i;
        r_j          <= n_j;
        r_rem        <= n_rem;
        r_status     <= n_status;
        r_page       <= n_page;
        r_out_status <= n_out_status;
        r_out_page   <= n_out_page;
        r_out_free   <= n_out_free;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_block_page = r_out_page;
    assign o_free_count = r_out_free;
endmodule
`default_nettype wire

>>> hdl/bpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bpa_props (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  o_status,
    input wire logic [15:0] o_block_page,
    input wire logic [16:0] o_free_count
);
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status))
    `CHK_IMPLY(a_status_range, i_clk, i_rst_n, o_valid, o_status <= bpa_pkg::ST_INVALID)
    `CHK_IMPLY(a_fail_pg, i_clk, i_rst_n, o_valid && o_status != bpa_pkg::ST_OK, ~|o_block_page)
    `CHK_IMPLY(a_free_bound, i_clk, i_rst_n, o_valid, o_free_count <= 17'd65536)
endmodule

bind buddy_page_allocator bpa_props u_bpa_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_status    (o_status),
    .o_block_page(o_block_page),
    .o_free_count(o_free_count)
);
`default_nettype wire

>>> bench/bpa_checker.sv
`timescale 1ns / 1ps
module bpa_checker #(
    parameter int PAGE_BITS = bpa_pkg::BPA_PAGE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [1:0]  i_func,
    input  logic [16:0] i_page_count,
    input  logic [15:0] i_page_index,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic [15:0] i_block_page,
    input  logic [16:0] i_free_count,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output int          o_fails
);

    localparam int unsigned SPACE = (PAGE_BITS < 16) ? (1 << PAGE_BITS) : 65536;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] page;
        logic [16:0] total;
    } t_reply;

    bit           pg_free[SPACE];
    logic [4:0]   pg_ord[SPACE];
    int unsigned  reg_start, reg_pages, free_sum, top_ord;
    t_reply       reply_q[$];

    function automatic int unsigned order_of(int unsigned n);
        int unsigned k, s;
        k = 0;
        s = 1;
        while (s < n) begin
            s = s << 1;
            k++;
        end
        return k;
    endfunction

    function automatic int unsigned region_limit();
        int unsigned e;
        e = reg_start + reg_pages;
        if (e > SPACE) e = SPACE;
        return e;
    endfunction

    function automatic void clear_pages();
        foreach (pg_free[p]) begin
            pg_free[p] = 1'b0;
            pg_ord[p]  = '0;
        end
        free_sum = 0;
    endfunction

    // carve the region into the largest aligned power-of-two blocks
    function automatic void carve_region();
        int unsigned lo, hi, rem, p, o;
        lo  = reg_start;
        hi  = region_limit();
        rem = (hi > lo) ? hi - lo : 0;
        p   = lo;
        clear_pages();
        top_ord = 0;
        while ((2 << top_ord) <= rem) top_ord++;
        while (rem > 0) begin
            o = 0;
            while ((2 << o) <= rem) o++;
            while (o > 0 && (p & ((1 << o) - 1)) != 0) o--;
            pg_free[p] = 1'b1;
            pg_ord[p]  = 5'(o);
            free_sum += 1 << o;
            p   += 1 << o;
            rem -= 1 << o;
        end
    endfunction

    function automatic logic [2:0] take_block(int unsigned n, output int unsigned page);
        int unsigned want, step, half;
        page = 0;
        if (n == 0) return bpa_pkg::ST_ZERO;
        if (n > free_sum) return bpa_pkg::ST_EXCEED;
        want = order_of(n);
        for (int unsigned i = want; i <= top_ord; i++) begin
            step = 1 << i;
            for (int unsigned a = 0; a < SPACE; a += step) begin
                if (pg_free[a] && pg_ord[a] == i) begin
                    pg_free[a] = 1'b0;
                    pg_ord[a]  = '0;
                    free_sum  -= step;
                    for (int unsigned j = i; j > want; j--) begin
                        half = 1 << (j - 1);
                        pg_free[a + half] = 1'b1;
                        pg_ord[a + half]  = 5'(j - 1);
                        free_sum += half;
                    end
                    page = a;
                    return bpa_pkg::ST_OK;
                end
            end
        end
        return bpa_pkg::ST_NOBLOCK;
    endfunction

    function automatic logic [2:0] release_block(int unsigned n, int unsigned base);
        int unsigned ord, size, lo, hi, a, buddy;
        if (n == 0) return bpa_pkg::ST_ZERO;
        ord = order_of(n);
        if (ord > 16) return bpa_pkg::ST_INVALID;
        size = 1 << ord;
        lo   = reg_start;
        hi   = region_limit();
        if (base < lo || base >= hi || size > hi - base) return bpa_pkg::ST_INVALID;
        if ((base & (size - 1)) != 0) return bpa_pkg::ST_INVALID;
        if (free_sum + size > 65536) return bpa_pkg::ST_INVALID;
        for (int unsigned p = base; p < base + size; p++) begin
            if (pg_free[p]) return bpa_pkg::ST_INVALID;
        end
        // reject a block that sits inside a larger free block
        for (int unsigned j = 1; j <= 16; j++) begin
            a = base & ~((1 << j) - 1);
            if (a < base && pg_free[a] && base - a < (1 << pg_ord[a]))
                return bpa_pkg::ST_INVALID;
        end
        free_sum += size;
        while (ord < top_ord) begin
            buddy = base ^ size;
            if (buddy >= SPACE) break;
            if (!pg_free[buddy] || pg_ord[buddy] != ord) break;
            pg_free[buddy] = 1'b0;
            pg_ord[buddy]  = '0;
            if (buddy < base) base = buddy;
            ord++;
            size = size << 1;
        end
        pg_free[base] = 1'b1;
        pg_ord[base]  = 5'(ord);
        return bpa_pkg::ST_OK;
    endfunction

    function automatic t_reply predict_reply(logic [1:0] f, int unsigned n,
                                             int unsigned idx);
        t_reply       r;
        int unsigned  page;
        page     = 0;
        r.status = bpa_pkg::ST_OK;
        if (f == bpa_pkg::FN_ALLOC) r.status = take_block(n, page);
        else if (f == bpa_pkg::FN_FREE) r.status = release_block(n, idx);
        else if (f == bpa_pkg::FN_INIT) carve_region();
        if (r.status != bpa_pkg::ST_OK) page = 0;
        r.page  = page[15:0];
        r.total = free_sum[16:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            reg_start = 0;
            reg_pages = 0;
            top_ord   = 0;
            clear_pages();
            reply_q.delete();
            o_fails   = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (reply_q.size() == 0) begin
                    $error("unexpected reply: status %0d block_page %0d free_count %0d",
                           i_status, i_block_page, i_free_count);
                    o_fails++;
                end else begin
                    want = reply_q.pop_front();
                    if (i_status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, i_status);
                        o_fails++;
                    end
                    if (i_block_page !== want.page) begin
                        $error("block_page expected %0d got %0d", want.page, i_block_page);
                        o_fails++;
                    end
                    if (i_free_count !== want.total) begin
                        $error("free_count expected %0d got %0d", want.total, i_free_count);
                        o_fails++;
                    end
                end
            end
            // a request sees the region registers as they stood before this edge
            if (i_valid && i_ready_in)
                reply_q.push_back(predict_reply(i_func, i_page_count, i_page_index));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == bpa_pkg::CFG_REGION_START) reg_start = i_cfg_data[15:0];
                else if (i_cfg_index == bpa_pkg::CFG_REGION_PAGES) reg_pages = i_cfg_data;
            end
        end
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam longint LIMIT = 64'd300_000_000;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready;
    logic [1:0]  i_func;
    logic [16:0] i_page_count;
    logic [15:0] i_page_index;
    logic        o_valid, i_ready;
    logic [2:0]  o_status;
    logic [15:0] o_block_page;
    logic [16:0] o_free_count;
    logic        i_cfg_valid, o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [16:0] i_cfg_data;
    int          fails;

    typedef struct {
        logic [1:0]  func;
        logic [16:0] count;
    } t_cmd;

    typedef struct {
        logic [15:0] page;
        logic [16:0] count;
    } t_block;

    t_cmd   inflight_q[$];
    t_block held_q[$];
    longint cycles;
    int     burst_left, stall_mode, stall_cnt;
    bit     no_gaps;

    buddy_page_allocator dut (.*);

    bpa_checker u_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_in(o_ready),
        .i_func(i_func), .i_page_count(i_page_count), .i_page_index(i_page_index),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_status(o_status), .i_block_page(o_block_page), .i_free_count(o_free_count),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fails(fails)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stall pattern: each mode is picked at random from three
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 1);
            default: i_ready <= (stall_cnt % 4 != 0);
        endcase
    end

    // track outstanding requests and the blocks handed out
    always @(posedge i_clk) begin
        t_cmd c;
        t_block b;
        if (i_rst_n) begin
            if (o_valid && i_ready && inflight_q.size() != 0) begin
                c = inflight_q.pop_front();
                if (c.func == bpa_pkg::FN_ALLOC && o_status == bpa_pkg::ST_OK) begin
                    b.page  = o_block_page;
                    b.count = c.count;
                    held_q.push_back(b);
                end
            end
            if (i_valid && o_ready) begin
                c.func  = i_func;
                c.count = i_page_count;
                inflight_q.push_back(c);
            end
        end
    end

    task automatic issue(logic [1:0] f, logic [16:0] n, logic [15:0] idx);
        i_valid      <= 1'b1;
        i_func       <= f;
        i_page_count <= n;
        i_page_index <= idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (!no_gaps && burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 12);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (inflight_q.size() != 0) @(posedge i_clk);
    endtask

    // leave valid up; the caller drops it after the last write
    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_region(int unsigned start, int unsigned pages);
        drain();
        write_reg(bpa_pkg::CFG_REGION_START, 17'(start));
        write_reg(bpa_pkg::CFG_REGION_PAGES, 17'(pages));
        i_cfg_valid <= 1'b0;
        held_q.delete();
        issue(bpa_pkg::FN_INIT, 17'($urandom), 16'($urandom));
    endtask

    task automatic random_item(int unsigned start, int unsigned pages);
        int     r, k;
        t_block b;
        logic [16:0] n;
        r = $urandom_range(0, 99);
        n = 17'($urandom_range(1, 8));
        if ($urandom_range(0, 3) == 0) n = 17'($urandom_range(1, pages / 2 + 1));
        if ($urandom_range(0, 19) == 0) n = 17'($urandom);
        if (r >= 45 && r < 85 && held_q.size() != 0) begin
            k = $urandom_range(0, held_q.size() - 1);
            b = held_q[k];
            held_q.delete(k);
            issue(bpa_pkg::FN_FREE, b.count, b.page);
        end else if (r >= 85 && r < 90) begin
            issue(bpa_pkg::FN_FREE, n, ($urandom_range(0, 1) == 1) ? 16'($urandom)
                              : 16'(start + $urandom_range(0, 64)));
        end else if (r >= 90 && r < 95) begin
            issue(($urandom_range(0, 1) == 1) ? bpa_pkg::FN_FREE : bpa_pkg::FN_ALLOC,
                  '0, 16'($urandom));
        end else if (r >= 95 && r < 98) begin
            issue(bpa_pkg::FN_NOP, 17'($urandom), 16'($urandom));
        end else if (r >= 98) begin
            issue(bpa_pkg::FN_INIT, 17'($urandom), 16'($urandom));
        end else begin
            issue(bpa_pkg::FN_ALLOC, n, 16'($urandom));
        end
    endtask

    initial begin
        int unsigned starts[9] = '{0, 0, 3, 100, 40000, 65000, 65535, 0, 12};
        int unsigned sizes[9]  = '{64, 65536, 61, 300, 1000, 2000, 65536, 96, 0};
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_func       = bpa_pkg::FN_ALLOC;
        i_page_count = '0;
        i_page_index = '0;
        i_ready      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = bpa_pkg::CFG_REGION_START;
        i_cfg_data   = '0;
        cycles       = 0;
        stall_cnt    = 0;
        stall_mode   = 0;
        burst_left   = 0;
        no_gaps      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty region straight after reset
        issue(bpa_pkg::FN_ALLOC, 17'd0, 16'd0);
        issue(bpa_pkg::FN_ALLOC, 17'd1, 16'd0);
        issue(bpa_pkg::FN_FREE, 17'd0, 16'd0);
        issue(bpa_pkg::FN_FREE, 17'd1, 16'd0);
        issue(bpa_pkg::FN_NOP, 17'h1FFFF, 16'hFFFF);

        // whole page space
        set_region(0, 65536);
        issue(bpa_pkg::FN_ALLOC, 17'd65536, 16'd0);
        issue(bpa_pkg::FN_ALLOC, 17'd1, 16'd0);
        issue(bpa_pkg::FN_FREE, 17'd65536, 16'd0);
        issue(bpa_pkg::FN_ALLOC, 17'd3, 16'd0);
        issue(bpa_pkg::FN_ALLOC, 17'd1, 16'd0);
        issue(bpa_pkg::FN_FREE, 17'd1, 16'd5);
        issue(bpa_pkg::FN_FREE, 17'd2, 16'd1);
        issue(bpa_pkg::FN_FREE, 17'd1, 16'd65535);
        issue(bpa_pkg::FN_FREE, 17'd4, 16'd0);
        issue(bpa_pkg::FN_FREE, 17'h1FFFF, 16'd0);
        issue(bpa_pkg::FN_ALLOC, 17'h1FFFF, 16'd0);

        // request above top order
        set_region(0, 96);
        issue(bpa_pkg::FN_ALLOC, 17'd65, 16'd0);

        for (int ph = 0; ph < 9; ph++) begin
            set_region(starts[ph], sizes[ph]);
            no_gaps = (ph % 3 == 1);
            for (int i = 0; i < 68; i++) random_item(starts[ph], sizes[ph]);
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
